@@ src/rcp_pkg.sv @@
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared types and constants for the rational curve pixel classifier.
// ----------------------------------------------------------------------------
package rcp_pkg;

  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = 5;

  localparam logic [1:0] SYM_BLANK = 2'd0;
  localparam logic [1:0] SYM_CURVE = 2'd1;
  localparam logic [1:0] SYM_AXIS  = 2'd2;

  typedef struct packed {
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [1:0] symbol;
    logic       den_zero;
    logic       saturated;
  } out_item_t;

  // Classified work handed from the front part to the back part.
  typedef struct packed {
    logic signed [31:0] num;
    logic signed [31:0] den;
    logic signed [35:0] ykey;
    logic               axis;
    logic               sat;
  } work_t;

endpackage

@@ src/rcp_horner.sv @@
// ----------------------------------------------------------------------------
// rcp_horner
// One Horner step: clamp32(floor(acc*x / 2^FRAC_BITS) + c), registered.
// ----------------------------------------------------------------------------
module rcp_horner #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] acc,
  input  logic signed [31:0] x,
  input  logic signed [31:0] coef,
  input  logic               sat_in,
  output logic signed [31:0] acc_r,
  output logic               sat_r
);

  logic signed [63:0] prod;
  logic signed [64:0] sum;
  logic signed [31:0] acc_nxt;
  logic               sat_nxt;

  always_comb begin
    prod = (64'(acc) * 64'(x)) >>> FRAC_BITS;
    sum  = 65'(prod) + 65'(coef);
    sat_nxt = sat_in;
    if (sum > 65'sd2147483647) begin
      acc_nxt = 32'sh7fffffff;
      sat_nxt = 1'b1;
    end else if (sum < -65'sd2147483648) begin
      acc_nxt = 32'sh80000000;
      sat_nxt = 1'b1;
    end else begin
      acc_nxt = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      sat_r <= sat_nxt;
    end
  end

endmodule

@@ src/rcp_front.sv @@
// ----------------------------------------------------------------------------
// rcp_front
// Pipelined evaluation of both polynomials and the x and y keys.
// ----------------------------------------------------------------------------
module rcp_front
  import rcp_pkg::*;
#(
  parameter int MAX_TERMS = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  in_item_t            in_item,
  input  logic signed [31:0]  num_coef [4],
  input  logic signed [31:0]  den_coef [4],
  output logic                vld_r,
  output work_t               work_r
);

  localparam int STEPS = MAX_TERMS - 1;
  localparam int DEPTH = STEPS + 1;

  logic signed [31:0] x_r    [DEPTH];
  logic signed [31:0] y_r    [DEPTH];
  logic signed [31:0] nacc_r [DEPTH];
  logic signed [31:0] dacc_r [DEPTH];
  logic               sat_r  [DEPTH];
  logic               v_r    [DEPTH];

  // Stage 0 loads the top coefficient.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
    end
    if (en) begin
      x_r[0]    <= in_item.x_coord;
      y_r[0]    <= in_item.y_coord;
      nacc_r[0] <= num_coef[MAX_TERMS-1];
      dacc_r[0] <= den_coef[MAX_TERMS-1];
      sat_r[0]  <= 1'b0;
    end
  end

  for (genvar s = 1; s < DEPTH; s++) begin : g_step
    logic               nsat;
    logic               dsat;
    rcp_horner #(.FRAC_BITS(FRAC_BITS)) u_num (
      .clk(clk), .en(en), .acc(nacc_r[s-1]), .x(x_r[s-1]),
      .coef(num_coef[MAX_TERMS-1-s]), .sat_in(sat_r[s-1]),
      .acc_r(nacc_r[s]), .sat_r(nsat)
    );
    rcp_horner #(.FRAC_BITS(FRAC_BITS)) u_den (
      .clk(clk), .en(en), .acc(dacc_r[s-1]), .x(x_r[s-1]),
      .coef(den_coef[MAX_TERMS-1-s]), .sat_in(1'b0),
      .acc_r(dacc_r[s]), .sat_r(dsat)
    );
    assign sat_r[s] = nsat | dsat;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
      if (en) begin
        x_r[s] <= x_r[s-1];
        y_r[s] <= y_r[s-1];
      end
    end
  end

  // ceil(10*v / 2^FRAC_BITS)
  function automatic logic signed [35:0] key10(input logic signed [31:0] v);
    logic signed [35:0] t;
    logic signed [35:0] q;
    t = (36'(v) <<< 3) + (36'(v) <<< 1);
    q = t >>> FRAC_BITS;
    if (t[FRAC_BITS-1:0] != '0) q = q + 36'sd1;
    return q;
  endfunction

  logic signed [35:0] xkey;
  logic signed [35:0] ykey;
  assign xkey = key10(x_r[DEPTH-1]);
  assign ykey = key10(y_r[DEPTH-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= v_r[DEPTH-1];
    end
    if (en) begin
      work_r.num  <= nacc_r[DEPTH-1];
      work_r.den  <= dacc_r[DEPTH-1];
      work_r.ykey <= ykey;
      work_r.axis <= (xkey == '0) || (ykey == '0);
      work_r.sat  <= sat_r[DEPTH-1];
    end
  end

endmodule

@@ src/rcp_fifo.sv @@
// ----------------------------------------------------------------------------
// rcp_fifo
// Short queue between the evaluator and the key compare.
// ----------------------------------------------------------------------------
module rcp_fifo
  import rcp_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  work_t wr_data,
  output logic  rd_vld,
  input  logic  rd_en,
  output work_t rd_data,
  output logic  [$clog2(DEPTH+1)-1:0] count_r
);

  localparam int AW = $clog2(DEPTH);

  work_t mem [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;

  assign rd_vld  = count_r != '0;
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      count_r <= count_r + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
    end
    if (wr_en) mem[wp_r] <= wr_data;
  end

endmodule

@@ src/rcp_back.sv @@
// ----------------------------------------------------------------------------
// rcp_back
// Quotient key compare. ceil(10*n/d) is found without a divider:
// k = ceil(10n/d) iff 10n <= k*d and 10n > (k-1)*d with d > 0.
// Stage A: clamp test and 10n, |d|, registered. Stage B: k*d compare into
// the output register.
// ----------------------------------------------------------------------------
module rcp_back
  import rcp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_vld,
  input  work_t     work,
  output logic      vld_r,
  output out_item_t item_r
);

  // Stage A
  logic signed [32:0] nn;
  logic signed [32:0] dd;
  logic signed [64:0] scaled;
  logic signed [64:0] hi_lim;
  logic signed [64:0] lo_lim;

  logic               a_vld_r;
  logic signed [36:0] a_ten_n_r;
  logic signed [32:0] a_dd_r;
  logic signed [35:0] a_ykey_r;
  logic               a_axis_r;
  logic               a_sat_r;
  logic               a_dz_r;
  logic               a_hi_r;
  logic               a_lo_r;

  localparam logic signed [35:0] KEY_MAX = 36'((64'sd21474836470 +
                                  (64'sd1 <<< FRAC_BITS) - 1) >>> FRAC_BITS);
  localparam logic signed [35:0] KEY_MIN = 36'(-(64'sd21474836480 >>> FRAC_BITS));

  always_comb begin
    nn = (work.den < 0) ? -33'(work.num) : 33'(work.num);
    dd = (work.den < 0) ? -33'(work.den) : 33'(work.den);
    scaled = 65'(nn) <<< FRAC_BITS;
    hi_lim = 65'(dd) * 65'sd2147483647;
    lo_lim = -(65'(dd) <<< 31);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
    if (en) begin
      a_ten_n_r <= (37'(nn) <<< 3) + (37'(nn) <<< 1);
      a_dd_r    <= dd;
      a_ykey_r  <= work.ykey;
      a_axis_r  <= work.axis;
      a_sat_r   <= work.sat;
      a_dz_r    <= work.den == '0;
      a_hi_r    <= scaled > hi_lim;
      a_lo_r    <= scaled < lo_lim;
    end
  end

  // Stage B: test k = ykey
  logic signed [70:0] kd;
  logic signed [70:0] km1d;
  logic               match;
  logic               sat;

  always_comb begin
    kd   = 71'(a_ykey_r) * 71'(a_dd_r);
    km1d = kd - 71'(a_dd_r);
    sat  = a_sat_r | (!a_dz_r && (a_hi_r || a_lo_r));
    if (a_dz_r)      match = 1'b0;
    else if (a_hi_r) match = a_ykey_r == KEY_MAX;
    else if (a_lo_r) match = a_ykey_r == KEY_MIN;
    else             match = (71'(a_ten_n_r) <= kd) && (71'(a_ten_n_r) > km1d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= a_vld_r;
    end
    if (en) begin
      item_r.symbol    <= a_axis_r ? SYM_AXIS : (match ? SYM_CURVE : SYM_BLANK);
      item_r.den_zero  <= a_dz_r;
      item_r.saturated <= sat;
    end
  end

endmodule

@@ src/rational_curve_plot_pixel_classifier.sv @@
// ----------------------------------------------------------------------------
// rational_curve_plot_pixel_classifier
// Classifies plot points against a rational curve num(x)/den(x).
//
//   channel  ports                            beat
//   input    in_valid/in_ready/in_data        x_coord, y_coord
//   output   out_valid/out_ready/out_data     symbol, den_zero, saturated
//   config   cfg_psel..cfg_prdata (APB)       coefficient registers 0..7
//
// One point per cycle sustained while in_ready and out_ready allow; points pass
// through the Horner pipeline, the queue and the two-stage key compare.
// The front pipeline never stalls; a point is taken only while the queue has
// room for it and every point in flight. The back stages advance whenever
// the output register is free. Reset is synchronous and clears valids,
// queue pointers and coefficients, but sets den coefficient 0 to 1.0.
// ----------------------------------------------------------------------------
module rational_curve_plot_pixel_classifier
  import rcp_pkg::*;
#(
  parameter int MAX_TERMS = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int QDEPTH = 8;
  localparam int FLIGHT = MAX_TERMS + 1;

  logic signed [31:0] num_coef_r [4];
  logic signed [31:0] den_coef_r [4];
  logic [2:0] ridx;
  assign ridx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        num_coef_r[i] <= '0;
        den_coef_r[i] <= '0;
      end
      den_coef_r[0] <= 32'sd1 <<< FRAC_BITS;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (!ridx[2]) num_coef_r[ridx[1:0]] <= cfg_pwdata;
      else          den_coef_r[ridx[1:0]] <= cfg_pwdata;
    end
  end

  always_comb begin
    if (cfg_paddr[1:0] != 2'b00) cfg_prdata = '0;
    else if (!ridx[2])           cfg_prdata = num_coef_r[ridx[1:0]];
    else                         cfg_prdata = den_coef_r[ridx[1:0]];
  end

  // Front: take a point only while the queue can absorb every point in flight.
  logic       f_vld;
  work_t      f_work;
  logic [$clog2(QDEPTH+1)-1:0] q_count;
  logic [$clog2(QDEPTH+2)-1:0] pend;
  logic       q_vld;
  work_t      q_data;
  logic       b_en;
  logic       q_rd;
  logic       b_vld;
  out_item_t  b_item;
  logic [3:0] infl_r;

  // Points inside the front pipeline (not yet in the queue).
  always_ff @(posedge clk) begin
    if (!rst_n) infl_r <= '0;
    else infl_r <= infl_r + ((in_valid && in_ready) ? 4'd1 : 4'd0)
                          - (f_vld ? 4'd1 : 4'd0);
  end
  assign pend = ($bits(pend))'(q_count) + ($bits(pend))'(infl_r);
  assign in_ready = pend < ($bits(pend))'(QDEPTH);

  rcp_front #(.MAX_TERMS(MAX_TERMS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(1'b1),
    .in_vld(in_valid && in_ready), .in_item(in_data),
    .num_coef(num_coef_r), .den_coef(den_coef_r),
    .vld_r(f_vld), .work_r(f_work)
  );

  rcp_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(f_vld), .wr_data(f_work),
    .rd_vld(q_vld), .rd_en(q_rd), .rd_data(q_data), .count_r(q_count)
  );

  // Back pipeline stalls as a whole when the output beat is not taken.
  logic a_busy;
  assign b_en = !out_valid || out_ready;
  assign q_rd = q_vld && b_en;
  assign a_busy = FLIGHT > 0;

  rcp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .en(b_en && a_busy),
    .in_vld(q_rd), .work(q_data),
    .vld_r(b_vld), .item_r(b_item)
  );

  assign out_valid = b_vld;
  assign out_data  = b_item;

endmodule
